// File: src/fpsr_pkg.sv
// shared types, constants and helpers for the flow packet sequence recorder
// no dependencies; imported by the interfaces and every module

package fpsr_pkg;

  localparam int COUNT_W  = 6;
  localparam int SLOT_W   = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] MAX_ELEMENTS = COUNT_W'(32);
  localparam logic [31:0]        WRAP_LIMIT   = 32'd4252017623;

  // outcome codes
  localparam logic [1:0] OUT_DUPLICATE = 2'd0;
  localparam logic [1:0] OUT_ZERO_SKIP = 2'd1;
  localparam logic [1:0] OUT_RECORDED  = 2'd2;
  localparam logic [1:0] OUT_FULL      = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_ZERO = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_DUP     = CFG_IDX_W'(1);

  typedef struct packed {
    logic        new_flow;
    logic        from_client;
    logic        is_tcp;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] payload_length;
    logic [15:0] wire_length;
    logic [7:0]  flag_bits;
    logic [31:0] time_seconds;
    logic [19:0] time_micros;
  } pkt_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [SLOT_W-1:0]  slot_index;
    logic [15:0]        recorded_size;
    logic [7:0]         recorded_flags;
    logic               recorded_direction;
    logic [31:0]        recorded_seconds;
    logic [19:0]        recorded_micros;
    logic [COUNT_W-1:0] element_count;
  } res_t;

  typedef struct packed {
    logic include_zero;
    logic skip_dup;
  } cfg_t;

  // true when cur does not move past prev, allowing for wrap
  function automatic logic not_advancing(input logic [31:0] cur, input logic [31:0] prev);
    logic [31:0] diff;
    diff = prev - cur;
    return (cur <= prev) && (diff <= WRAP_LIMIT);
  endfunction

endpackage

// File: src/fpsr_pkt_if.sv
// packet input channel: valid/ready handshake plus packet fields
// depends on fpsr_pkg

interface fpsr_pkt_if;
  import fpsr_pkg::*;

  logic        valid;
  logic        ready;
  logic        new_flow;
  logic        from_client;
  logic        is_tcp;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [15:0] payload_length;
  logic [15:0] wire_length;
  logic [7:0]  flag_bits;
  logic [31:0] time_seconds;
  logic [19:0] time_micros;

  modport source (
    output valid, new_flow, from_client, is_tcp, seq_number, ack_number,
           payload_length, wire_length, flag_bits, time_seconds, time_micros,
    input  ready
  );

  modport sink (
    input  valid, new_flow, from_client, is_tcp, seq_number, ack_number,
           payload_length, wire_length, flag_bits, time_seconds, time_micros,
    output ready
  );
endinterface

// File: src/fpsr_res_if.sv
// result output channel: valid/ready handshake plus result fields
// depends on fpsr_pkg

interface fpsr_res_if;
  import fpsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic [SLOT_W-1:0]  slot_index;
  logic [15:0]        recorded_size;
  logic [7:0]         recorded_flags;
  logic               recorded_direction;
  logic [31:0]        recorded_seconds;
  logic [19:0]        recorded_micros;
  logic [COUNT_W-1:0] element_count;

  modport source (
    output valid, outcome, slot_index, recorded_size, recorded_flags,
           recorded_direction, recorded_seconds, recorded_micros, element_count,
    input  ready
  );

  modport sink (
    input  valid, outcome, slot_index, recorded_size, recorded_flags,
           recorded_direction, recorded_seconds, recorded_micros, element_count,
    output ready
  );
endinterface

// File: src/fpsr_cfg_if.sv
// configuration write channel: valid/ready handshake, register index and data
// depends on fpsr_pkg

interface fpsr_cfg_if;
  import fpsr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/fpsr_flow_state.sv
// per-direction last values, element count and the duplicate/record decision
// depends on fpsr_pkg

module fpsr_flow_state (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  fpsr_pkg::pkt_t pkt,
  input  fpsr_pkg::cfg_t cfg,
  output fpsr_pkg::res_t res
);
  import fpsr_pkg::*;

  logic [31:0]        last_seq    [2];
  logic [31:0]        last_ack    [2];
  logic [15:0]        last_length [2];
  logic [7:0]         last_flags  [2];
  logic [COUNT_W-1:0] count;

  logic               dir;
  logic [31:0]        prev_seq;
  logic [31:0]        prev_ack;
  logic [15:0]        prev_length;
  logic [7:0]         prev_flags;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] count_next;
  logic               is_dup;
  logic               do_update;

  // direction 0 is client to server
  assign dir = ~pkt.from_client;

  // a new flow sees cleared state
  always_comb begin
    if (pkt.new_flow) begin
      prev_seq    = '0;
      prev_ack    = '0;
      prev_length = '0;
      prev_flags  = '0;
      cur_count   = '0;
    end else begin
      prev_seq    = last_seq[dir];
      prev_ack    = last_ack[dir];
      prev_length = last_length[dir];
      prev_flags  = last_flags[dir];
      cur_count   = count;
    end
  end

  assign is_dup = cfg.skip_dup && pkt.is_tcp
               && not_advancing(pkt.seq_number, prev_seq)
               && not_advancing(pkt.ack_number, prev_ack)
               && (pkt.payload_length == prev_length)
               && (pkt.flag_bits == prev_flags)
               && (cur_count != '0);

  assign do_update = !is_dup;

  always_comb begin
    res        = '0;
    count_next = cur_count;
    if (is_dup) begin
      res.outcome = OUT_DUPLICATE;
    end else if (pkt.wire_length == '0 && !cfg.include_zero) begin
      res.outcome = OUT_ZERO_SKIP;
    end else if (cur_count < MAX_ELEMENTS) begin
      res.outcome            = OUT_RECORDED;
      res.slot_index         = cur_count[SLOT_W-1:0];
      res.recorded_size      = pkt.wire_length;
      res.recorded_flags     = pkt.flag_bits;
      res.recorded_direction = pkt.from_client;
      res.recorded_seconds   = pkt.time_seconds;
      res.recorded_micros    = pkt.time_micros;
      count_next             = cur_count + COUNT_W'(1);
    end else begin
      res.outcome = OUT_FULL;
    end
    res.element_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int i = 0; i < 2; i++) begin
        last_seq[i]    <= '0;
        last_ack[i]    <= '0;
        last_length[i] <= '0;
        last_flags[i]  <= '0;
      end
    end else if (advance) begin
      count <= count_next;
      for (int i = 0; i < 2; i++) begin
        if (do_update && dir == 1'(i)) begin
          last_seq[i]    <= pkt.seq_number;
          last_ack[i]    <= pkt.ack_number;
          last_length[i] <= pkt.payload_length;
          last_flags[i]  <= pkt.flag_bits;
        end else if (pkt.new_flow) begin
          last_seq[i]    <= '0;
          last_ack[i]    <= '0;
          last_length[i] <= '0;
          last_flags[i]  <= '0;
        end
      end
    end
  end

endmodule

// File: src/flow_packet_sequence_recorder.sv
// top level of the flow packet sequence recorder
// depends on fpsr_pkg, the channel interfaces and fpsr_flow_state
//
// path: a packet transaction loads the input register, the result register loads
//   when that packet advances, and the result transaction is offered from there
// throughput: one packet per cycle unless res.ready stalls; per-flow state is
//   read and written in the compute step between the input and result registers
// reset: synchronous rst clears the flow state, both config registers and
//   the valid flags of the input and result registers

module flow_packet_sequence_recorder (
  input  logic  clk,
  input  logic  rst,
  fpsr_pkt_if.sink   pkt,
  fpsr_res_if.source res,
  fpsr_cfg_if.sink   cfg
);
  import fpsr_pkg::*;

  // configuration registers
  cfg_t cfg_regs;

  // input register stage
  logic s1_valid;
  pkt_t s1_pkt;

  // result register stage
  logic res_valid;
  res_t res_q;
  res_t res_comb;

  // the compute cycle happens when a packet is held and the result register is free or draining
  logic advance;

  assign advance   = s1_valid && (!res_valid || res.ready);
  assign pkt.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;

  // config register decode; writes outside the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_INCLUDE_ZERO: cfg_regs.include_zero <= cfg.data;
        CFG_SKIP_DUP:     cfg_regs.skip_dup     <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register: load on every input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt.ready) begin
      s1_valid <= pkt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      s1_pkt.new_flow       <= pkt.new_flow;
      s1_pkt.from_client    <= pkt.from_client;
      s1_pkt.is_tcp         <= pkt.is_tcp;
      s1_pkt.seq_number     <= pkt.seq_number;
      s1_pkt.ack_number     <= pkt.ack_number;
      s1_pkt.payload_length <= pkt.payload_length;
      s1_pkt.wire_length    <= pkt.wire_length;
      s1_pkt.flag_bits      <= pkt.flag_bits;
      s1_pkt.time_seconds   <= pkt.time_seconds;
      s1_pkt.time_micros    <= pkt.time_micros;
    end
  end

  // decision logic and flow state, updated when the packet moves on
  fpsr_flow_state u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pkt     (s1_pkt),
    .cfg     (cfg_regs),
    .res     (res_comb)
  );

  // result register: holds until the downstream transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign res.valid              = res_valid;
  assign res.outcome            = res_q.outcome;
  assign res.slot_index         = res_q.slot_index;
  assign res.recorded_size      = res_q.recorded_size;
  assign res.recorded_flags     = res_q.recorded_flags;
  assign res.recorded_direction = res_q.recorded_direction;
  assign res.recorded_seconds   = res_q.recorded_seconds;
  assign res.recorded_micros    = res_q.recorded_micros;
  assign res.element_count      = res_q.element_count;

endmodule
